[rtl/bws_pkg.sv]
// Shared types and constants of the battery wake sequencer.
package bws_pkg;

   // Sequence states as shown on seq_state.
   localparam logic [2:0] PH_INIT  = 3'd0;
   localparam logic [2:0] PH_SAFE  = 3'd1;
   localparam logic [2:0] PH_MAIN  = 3'd2;
   localparam logic [2:0] PH_AWAIT = 3'd3;
   localparam logic [2:0] PH_RUN   = 3'd4;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_SETTLE      = 2'd0;
   localparam logic [1:0] CSR_WAKE_DELAY  = 2'd1;
   localparam logic [1:0] CSR_TX_INTERVAL = 2'd2;

   // Register reset values in milliseconds.
   localparam logic [15:0] SETTLE_RESET      = 16'd500;
   localparam logic [15:0] WAKE_DELAY_RESET  = 16'd1000;
   localparam logic [15:0] TX_INTERVAL_RESET = 16'd100;

   // Input operation codes.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_STATUS = 1'b1;

   // Bit positions inside the status byte.
   localparam int STATUS_STANDBY_BIT = 1;
   localparam int STATUS_ERROR_BIT   = 6;

   typedef struct packed {
      logic [15:0] settle_ms;
      logic [15:0] wake_delay_ms;
      logic [15:0] tx_interval_ms;
   } cfg_type;

   // Sequencer state apart from the time stamps.
   typedef struct packed {
      logic [2:0] phase;
      logic       safe_on;
      logic       main_on;
      logic       wake_on;
      logic [7:0] alive_count;
      logic       heard_status;
      logic       standby_seen;
      logic       error_seen;
   } ctrl_type;

   typedef struct packed {
      logic       safe_supply_on;
      logic       main_supply_on;
      logic       wake_on;
      logic [2:0] seq_state;
      logic       tx_valid;
      logic       tx_use_request;
      logic [7:0] tx_alive;
   } result_type;

endpackage

[rtl/bws_channels.sv]
// Handshake channel interfaces of the battery wake sequencer.
interface bws_req_chan;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] now_ms;
   logic [7:0]  status_byte;

   modport source (output valid, output op, output now_ms, output status_byte, input ready);
   modport sink   (input valid, input op, input now_ms, input status_byte, output ready);
endinterface

interface bws_rsp_chan;
   logic       valid;
   logic       ready;
   logic       safe_supply_on;
   logic       main_supply_on;
   logic       wake_on;
   logic [2:0] seq_state;
   logic       tx_valid;
   logic       tx_use_request;
   logic [7:0] tx_alive;

   modport source (output valid, output safe_supply_on, output main_supply_on,
                   output wake_on, output seq_state, output tx_valid,
                   output tx_use_request, output tx_alive, input ready);
   modport sink   (input valid, input safe_supply_on, input main_supply_on,
                   input wake_on, input seq_state, input tx_valid,
                   input tx_use_request, input tx_alive, output ready);
endinterface

interface bws_csr_chan;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/battery_wake_sequencer.sv]
// Battery power-up sequencer with heartbeat generation (top level).
//
//   channel  | dir | payload                                   | transfer when
//   ---------+-----+-------------------------------------------+-----------------------
//   req_if   | in  | op, now_ms, status_byte                   | valid && ready
//   rsp_if   | out | lines, seq_state, tx_valid/use/alive      | valid && ready
//   csr_if   | in  | index, data (settle, wake delay, interval)| valid && ready (always)
//
// The sequencer state and the result register are updated at the edge where a request
// transfers, so one item per cycle is sustained while the result side takes every
// result. The result register is the only stage; a request is taken whenever that
// register is empty or is being drained in the same cycle.
// Reset (synchronous, active high) returns the sequence to its init state,
// drops all lines, clears the status flags, the time stamps and the alive
// counter, and loads the register defaults. A stalled result holds its value
// and stalls the request side only while it is not taken.
module battery_wake_sequencer #(
   parameter int TIME_WIDTH = 32
) (
   input logic           clock,
   input logic           reset,
   bws_req_chan.sink     req_if,
   bws_rsp_chan.source   rsp_if,
   bws_csr_chan.sink     csr_if
);

   // Configuration registers.
   bws_pkg::cfg_type      cfg_ff;
   bws_pkg::cfg_type      cfg_in;

   // Sequencer state.
   bws_pkg::ctrl_type     ctrl_ff;
   bws_pkg::ctrl_type     ctrl_in;
   logic [TIME_WIDTH-1:0] entry_time_ff;
   logic [TIME_WIDTH-1:0] entry_time_in;
   logic [TIME_WIDTH-1:0] send_time_ff;
   logic [TIME_WIDTH-1:0] send_time_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   bws_pkg::result_type   rsp_data_ff;
   bws_pkg::result_type   rsp_data_in;

   logic                  req_take;

   // Space in the result register: empty, or its content leaves this cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_take     = req_if.valid && req_if.ready;

   // Registers may be written in any cycle.
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            bws_pkg::CSR_SETTLE:      cfg_in.settle_ms      = csr_if.data;
            bws_pkg::CSR_WAKE_DELAY:  cfg_in.wake_delay_ms  = csr_if.data;
            bws_pkg::CSR_TX_INTERVAL: cfg_in.tx_interval_ms = csr_if.data;
            default: begin
               // Writes to indexes beyond the register list are dropped.
            end
         endcase
      end
   end

   bws_step #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_step (
      .op             (req_if.op),
      .now_ms         (req_if.now_ms),
      .status_byte    (req_if.status_byte),
      .cfg            (cfg_ff),
      .ctrl_cur       (ctrl_ff),
      .entry_time_cur (entry_time_ff),
      .send_time_cur  (send_time_ff),
      .ctrl_nxt       (ctrl_in),
      .entry_time_nxt (entry_time_in),
      .send_time_nxt  (send_time_in),
      .result         (rsp_data_in)
   );

   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ms      <= bws_pkg::SETTLE_RESET;
         cfg_ff.wake_delay_ms  <= bws_pkg::WAKE_DELAY_RESET;
         cfg_ff.tx_interval_ms <= bws_pkg::TX_INTERVAL_RESET;
         ctrl_ff.phase         <= bws_pkg::PH_INIT;
         ctrl_ff.safe_on       <= 1'b0;
         ctrl_ff.main_on       <= 1'b0;
         ctrl_ff.wake_on       <= 1'b0;
         ctrl_ff.alive_count   <= 8'd0;
         ctrl_ff.heard_status  <= 1'b0;
         ctrl_ff.standby_seen  <= 1'b0;
         ctrl_ff.error_seen    <= 1'b0;
         entry_time_ff         <= '0;
         send_time_ff          <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            ctrl_ff       <= ctrl_in;
            entry_time_ff <= entry_time_in;
            send_time_ff  <= send_time_in;
         end
      end
   end

   // The payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.safe_supply_on = rsp_data_ff.safe_supply_on;
   assign rsp_if.main_supply_on = rsp_data_ff.main_supply_on;
   assign rsp_if.wake_on        = rsp_data_ff.wake_on;
   assign rsp_if.seq_state      = rsp_data_ff.seq_state;
   assign rsp_if.tx_valid       = rsp_data_ff.tx_valid;
   assign rsp_if.tx_use_request = rsp_data_ff.tx_use_request;
   assign rsp_if.tx_alive       = rsp_data_ff.tx_alive;

endmodule

[rtl/bws_step.sv]
// Next-state and result logic for one input item of the wake sequencer.
module bws_step #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                    op,
   input  logic [31:0]             now_ms,
   input  logic [7:0]              status_byte,
   input  bws_pkg::cfg_type        cfg,
   input  bws_pkg::ctrl_type       ctrl_cur,
   input  logic [TIME_WIDTH-1:0]   entry_time_cur,
   input  logic [TIME_WIDTH-1:0]   send_time_cur,
   output bws_pkg::ctrl_type       ctrl_nxt,
   output logic [TIME_WIDTH-1:0]   entry_time_nxt,
   output logic [TIME_WIDTH-1:0]   send_time_nxt,
   output bws_pkg::result_type     result
);

   logic [63:0]           now_wide;
   logic [63:0]           settle_wide;
   logic [63:0]           wake_wide;
   logic [63:0]           interval_wide;
   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] phase_elapsed;
   logic [TIME_WIDTH-1:0] send_elapsed;
   logic                  heartbeat;

   // Time is zero-extended or cut to the internal width.
   assign now_wide      = {32'd0, now_ms};
   assign settle_wide   = {48'd0, cfg.settle_ms};
   assign wake_wide     = {48'd0, cfg.wake_delay_ms};
   assign interval_wide = {48'd0, cfg.tx_interval_ms};
   assign now_t         = now_wide[TIME_WIDTH-1:0];

   // Wrap-around differences.
   assign phase_elapsed = now_t - entry_time_cur;
   assign send_elapsed  = now_t - send_time_cur;
   assign heartbeat     = (op == bws_pkg::OP_TICK) &&
                          (send_elapsed >= interval_wide[TIME_WIDTH-1:0]);

   always_comb begin
      ctrl_nxt       = ctrl_cur;
      entry_time_nxt = entry_time_cur;
      send_time_nxt  = send_time_cur;
      if (op == bws_pkg::OP_STATUS) begin
         ctrl_nxt.standby_seen = status_byte[bws_pkg::STATUS_STANDBY_BIT];
         ctrl_nxt.error_seen   = status_byte[bws_pkg::STATUS_ERROR_BIT];
         ctrl_nxt.heard_status = 1'b1;
      end else begin
         case (ctrl_cur.phase)
            bws_pkg::PH_INIT: begin
               ctrl_nxt.safe_on = 1'b1;
               ctrl_nxt.main_on = 1'b0;
               ctrl_nxt.wake_on = 1'b0;
               entry_time_nxt   = now_t;
               ctrl_nxt.phase   = bws_pkg::PH_SAFE;
            end
            bws_pkg::PH_SAFE: begin
               if (phase_elapsed >= settle_wide[TIME_WIDTH-1:0]) begin
                  ctrl_nxt.main_on = 1'b1;
                  entry_time_nxt   = now_t;
                  ctrl_nxt.phase   = bws_pkg::PH_MAIN;
               end
            end
            bws_pkg::PH_MAIN: begin
               if (phase_elapsed >= wake_wide[TIME_WIDTH-1:0]) begin
                  ctrl_nxt.wake_on = 1'b1;
                  entry_time_nxt   = now_t;
                  ctrl_nxt.phase   = bws_pkg::PH_AWAIT;
               end
            end
            bws_pkg::PH_AWAIT: begin
               if (ctrl_cur.heard_status && ctrl_cur.standby_seen) begin
                  ctrl_nxt.phase = bws_pkg::PH_RUN;
               end
            end
            default: begin
            end
         endcase
         if (heartbeat) begin
            send_time_nxt        = now_t;
            ctrl_nxt.alive_count = ctrl_cur.alive_count + 8'd1;
         end
      end
   end

   always_comb begin
      result.safe_supply_on = ctrl_nxt.safe_on;
      result.main_supply_on = ctrl_nxt.main_on;
      result.wake_on        = ctrl_nxt.wake_on;
      result.seq_state      = ctrl_nxt.phase;
      result.tx_valid       = heartbeat;
      result.tx_use_request = heartbeat && (ctrl_nxt.phase == bws_pkg::PH_RUN) &&
                              !ctrl_cur.error_seen;
      result.tx_alive       = heartbeat ? ctrl_cur.alive_count : 8'd0;
   end

endmodule

[rtl/bws_checker.sv]
// Port-level checks of the battery wake sequencer and their binding.
module bws_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       safe_supply_on,
   input logic       main_supply_on,
   input logic       wake_on,
   input logic [2:0] seq_state,
   input logic       tx_valid,
   input logic       tx_use_request,
   input logic [7:0] tx_alive
);

   // A pending result is not withdrawn.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // Supplies come up in order: wake needs main, main needs safe.
   a_line_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!wake_on || main_supply_on) && (!main_supply_on || safe_supply_on))
      else $error("supply lines out of order");

   // Use may only be requested in a heartbeat while running.
   a_use_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tx_use_request |-> tx_valid && seq_state == bws_pkg::PH_RUN)
      else $error("use request outside running heartbeat");

   // Without a heartbeat the frame fields are zero.
   a_quiet_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !tx_valid |-> !tx_use_request && tx_alive == 8'd0)
      else $error("heartbeat fields set without heartbeat");

   // Wake and running states always show the wake line.
   a_wake_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (seq_state == bws_pkg::PH_AWAIT || seq_state == bws_pkg::PH_RUN)
      |-> wake_on)
      else $error("wake line low in a late state");

endmodule

bind battery_wake_sequencer bws_checker u_bws_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .safe_supply_on (rsp_if.safe_supply_on),
   .main_supply_on (rsp_if.main_supply_on),
   .wake_on        (rsp_if.wake_on),
   .seq_state      (rsp_if.seq_state),
   .tx_valid       (rsp_if.tx_valid),
   .tx_use_request (rsp_if.tx_use_request),
   .tx_alive       (rsp_if.tx_alive)
);

[tb/battery_wake_sequencer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench: battery wake sequencer driven with timed calls and status frames.
module battery_wake_sequencer_tb;

   // The configuration port has four slots but only three registers; the last one is dead.
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RANDOM_PHASES = 5;
   localparam int unsigned ITEMS_PER_PHASE = 305;

   // One input item as the request channel carries it.
   typedef struct packed {
      logic        op;
      logic [31:0] now_ms;
      logic [7:0]  status_byte;
   } pack_input_type;

   logic clock = 1'b0;
   logic reset;

   bws_req_chan req_if ();
   bws_rsp_chan rsp_if ();
   bws_csr_chan csr_if ();

   battery_wake_sequencer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Our own copy of the register file, updated at the edge where a write transfers.
   logic [15:0] settle_cfg = bws_pkg::SETTLE_RESET;
   logic [15:0] wake_delay_cfg = bws_pkg::WAKE_DELAY_RESET;
   logic [15:0] tx_interval_cfg = bws_pkg::TX_INTERVAL_RESET;

   // Our own copy of the sequencer state, in its reset condition.
   logic [2:0]  pack_phase = bws_pkg::PH_INIT;
   logic [31:0] phase_start_ms = '0;
   logic [31:0] last_beat_ms = '0;
   logic [7:0]  alive_count = '0;
   logic        heard_status = 1'b0;
   logic        standby_seen = 1'b0;
   logic        error_seen = 1'b0;
   logic        safe_line = 1'b0;
   logic        main_line = 1'b0;
   logic        wake_line = 1'b0;

   pack_input_type      pending_inputs[$];
   bws_pkg::result_type expected_reports[$];
   bws_pkg::result_type report_due;

   int unsigned req_gap_max;
   int unsigned rsp_stall_max;
   int unsigned req_wait;
   int unsigned rsp_wait;
   int unsigned cycle_count = 0;
   logic [31:0] wall_ms;
   bit          failed = 1'b0;

   // Advances the sequencer by one input item and returns the report it must produce.
   // Time differences are 32-bit subtractions, so they wrap the same way the block does.
   function automatic bws_pkg::result_type sequence_step(input pack_input_type item);
      bws_pkg::result_type report;
      logic [31:0]         since_phase;
      logic [31:0]         since_beat;
      report = '0;
      if (item.op == bws_pkg::OP_STATUS) begin
         // A status frame only latches its bits; the sequence reacts on the next call.
         standby_seen = item.status_byte[bws_pkg::STATUS_STANDBY_BIT];
         error_seen = item.status_byte[bws_pkg::STATUS_ERROR_BIT];
         heard_status = 1'b1;
      end else begin
         since_phase = item.now_ms - phase_start_ms;
         case (pack_phase)
            bws_pkg::PH_INIT: begin
               safe_line = 1'b1;
               main_line = 1'b0;
               wake_line = 1'b0;
               phase_start_ms = item.now_ms;
               pack_phase = bws_pkg::PH_SAFE;
            end
            bws_pkg::PH_SAFE: begin
               if (since_phase >= {16'd0, settle_cfg}) begin
                  main_line = 1'b1;
                  phase_start_ms = item.now_ms;
                  pack_phase = bws_pkg::PH_MAIN;
               end
            end
            bws_pkg::PH_MAIN: begin
               if (since_phase >= {16'd0, wake_delay_cfg}) begin
                  wake_line = 1'b1;
                  phase_start_ms = item.now_ms;
                  pack_phase = bws_pkg::PH_AWAIT;
               end
            end
            bws_pkg::PH_AWAIT: begin
               if (heard_status && standby_seen) pack_phase = bws_pkg::PH_RUN;
            end
            default: ;
         endcase
         // The heartbeat sees the state after this call's step.
         since_beat = item.now_ms - last_beat_ms;
         if (since_beat >= {16'd0, tx_interval_cfg}) begin
            last_beat_ms = item.now_ms;
            report.tx_valid = 1'b1;
            report.tx_use_request = (pack_phase == bws_pkg::PH_RUN) && !error_seen;
            report.tx_alive = alive_count;
            alive_count = alive_count + 8'd1;
         end
      end
      report.safe_supply_on = safe_line;
      report.main_supply_on = main_line;
      report.wake_on = wake_line;
      report.seq_state = pack_phase;
      return report;
   endfunction

   task automatic compare_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         failed = 1'b1;
      end
   endtask

   task automatic queue_tick(input logic [31:0] now);
      pack_input_type item;
      item.op = bws_pkg::OP_TICK;
      item.now_ms = now;
      // The status byte is ignored on a periodic call, so it carries noise.
      item.status_byte = 8'($urandom);
      pending_inputs.push_back(item);
   endtask

   task automatic queue_status(input logic [7:0] status);
      pack_input_type item;
      item.op = bws_pkg::OP_STATUS;
      item.now_ms = $urandom;
      item.status_byte = status;
      pending_inputs.push_back(item);
   endtask

   // Random traffic: mostly periodic calls whose time moves forward by up to two heartbeat
   // intervals plus 1 ms, some status frames with random bits, and some calls whose time jumps
   // anywhere, backward included, so the wrap-around subtraction is hit from both sides.
   task automatic queue_traffic(input int unsigned count);
      int unsigned roll;
      repeat (count) begin
         roll = $urandom_range(99, 0);
         if (roll < 15) begin
            queue_status(8'($urandom));
         end else begin
            if (roll < 25) wall_ms = $urandom;
            else wall_ms = wall_ms + $urandom_range(2 * tx_interval_cfg + 1, 0);
            queue_tick(wall_ms);
         end
      end
   endtask

   // Must be entered right after a rising edge. Leaves valid high so that back-to-back
   // writes never lower and raise it within one time step.
   task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (index)
         bws_pkg::CSR_SETTLE:      settle_cfg = value;
         bws_pkg::CSR_WAKE_DELAY:  wake_delay_cfg = value;
         bws_pkg::CSR_TX_INTERVAL: tx_interval_cfg = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [15:0] settle, input logic [15:0] wake_delay,
                                 input logic [15:0] interval, input bit poke_unused);
      if (poke_unused) write_reg(CSR_UNUSED, 16'($urandom));
      write_reg(bws_pkg::CSR_SETTLE, settle);
      write_reg(bws_pkg::CSR_WAKE_DELAY, wake_delay);
      write_reg(bws_pkg::CSR_TX_INTERVAL, interval);
      csr_if.valid <= 1'b0;
   endtask

   // Holds the sender back until every queued item has transferred and every predicted
   // report has been checked. This is the only safe moment to touch the registers.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_inputs.size() != 0 || req_if.valid || expected_reports.size() != 0);
   endtask

   // Request driver. After each transfer it draws a gap of idle cycles; while the gap runs
   // valid stays low, otherwise the next pending item is presented at once. The report for
   // an item is predicted at the very edge where the item transfers.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_reports.push_back(sequence_step(pending_inputs.pop_front()));
            req_wait = $urandom_range(req_gap_max, 0);
         end else if (!req_if.valid && req_wait > 0) begin
            req_wait--;
         end
         // The slot is free when nothing is offered or the offered item just transferred.
         if (!req_if.valid || req_if.ready) begin
            if (req_wait == 0 && pending_inputs.size() > 0) begin
               req_if.valid <= 1'b1;
               req_if.op <= pending_inputs[0].op;
               req_if.now_ms <= pending_inputs[0].now_ms;
               req_if.status_byte <= pending_inputs[0].status_byte;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Report monitor. Each transfer is checked field by field against the oldest prediction,
   // then ready is dropped for a randomly drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_reports.size() == 0) begin
               $error("report transfer with no prediction pending");
               failed = 1'b1;
            end else begin
               report_due = expected_reports.pop_front();
               compare_field("safe_supply_on", 8'(report_due.safe_supply_on),
                             8'(rsp_if.safe_supply_on));
               compare_field("main_supply_on", 8'(report_due.main_supply_on),
                             8'(rsp_if.main_supply_on));
               compare_field("wake_on", 8'(report_due.wake_on), 8'(rsp_if.wake_on));
               compare_field("seq_state", 8'(report_due.seq_state), 8'(rsp_if.seq_state));
               compare_field("tx_valid", 8'(report_due.tx_valid), 8'(rsp_if.tx_valid));
               compare_field("tx_use_request", 8'(report_due.tx_use_request),
                             8'(rsp_if.tx_use_request));
               compare_field("tx_alive", report_due.tx_alive, rsp_if.tx_alive);
            end
            rsp_wait = $urandom_range(rsp_stall_max, 0);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_if.ready <= (rsp_wait == 0);
      end
   end

   // Watchdog. A correct run stays far below this even with the longest gaps and stalls.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.op = bws_pkg::OP_TICK;
      req_if.now_ms = '0;
      req_if.status_byte = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = bws_pkg::CSR_SETTLE;
      csr_if.data = '0;
      req_gap_max = 10;
      rsp_stall_max = 10;
      wall_ms = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Walk into the sequence with the reset values of the registers. A status frame that
      // reports no standby comes first, so the heard flag is already set in the await state.
      // The calls sit on both sides of the first heartbeat and of the settle time.
      @(negedge clock);
      queue_status(8'h00);
      queue_tick(32'd0);
      queue_tick(32'd99);
      queue_tick(32'd100);
      queue_tick(32'd499);
      queue_tick(32'd500);
      wait_drained();

      // Largest wake delay and heartbeat interval: one call just short of the wake delay,
      // one exactly on it. In the await state a call without standby must hold, and the
      // latched standby and error bits only count on the call after the frame.
      apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      @(negedge clock);
      queue_tick(32'd500 + 32'd65534);
      queue_tick(32'd500 + 32'd65535);
      queue_tick(32'd500 + 32'd65536);
      queue_status(8'h42);
      queue_tick(32'd500 + 32'd65537);
      wait_drained();

      // Zero interval sends a heartbeat on every call, even with an unchanged time. The use
      // request follows the error bit while running. The dead register slot is written too.
      apply_settings(16'h0000, 16'h0000, 16'h0000, 1'b1);
      @(negedge clock);
      queue_tick(32'd500 + 32'd65537);
      queue_status(8'h02);
      queue_tick(32'd500 + 32'd65537);
      queue_status(8'hBD);
      queue_tick(32'hFFFF_FFFF);
      queue_status(8'hFF);
      queue_tick(32'h8000_0000);
      wait_drained();

      // Smallest nonzero interval across the wrap of the millisecond counter.
      apply_settings(16'h0001, 16'h0001, 16'h0001, 1'b0);
      @(negedge clock);
      queue_tick(32'hFFFF_FFFF);
      queue_tick(32'h0000_0000);
      queue_tick(32'h0000_0000);
      queue_status(8'h00);
      queue_tick(32'h0000_0001);
      wait_drained();

      // Random phases, each with its own register settings and its own mix of sender gaps
      // and receiver stalls, including phases where one or both sides never idle.
      wall_ms = 32'hFFFF_FF00;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_settings(16'($urandom), 16'($urandom), 16'h0001, 1'b0);
            1: apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
            default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(300, 2)),
                                    1'b0);
         endcase
         @(negedge clock);
         req_gap_max = (p % 2) ? 0 : 10;
         rsp_stall_max = (p == 1 || p == 2) ? 0 : 10;
         queue_traffic(ITEMS_PER_PHASE);
         wait_drained();
      end

      // Everything has transferred and been checked; give the block time to show any
      // stray report before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && expected_reports.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
